// ===== src/mlc_pkg.sv =====
// Shared types and codes of the last-level cache directory controller.
package mlc_pkg;

   typedef enum logic [2:0] {
      REQ_DATA_READ   = 3'd0,
      REQ_WRITE       = 3'd1,
      REQ_INSTR_READ  = 3'd2,
      REQ_SNOOP_INVAL = 3'd3,
      REQ_SNOOP_READ  = 3'd4,
      REQ_SNOOP_WRITE = 3'd5,
      REQ_SNOOP_RWIM  = 3'd6,
      REQ_CLEAR       = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      CO_I = 2'd0,
      CO_S = 2'd1,
      CO_E = 2'd2,
      CO_M = 2'd3
   } co_type;

   typedef enum logic [1:0] {
      BUS_NONE  = 2'd0,
      BUS_READ  = 2'd1,
      BUS_RWIM  = 2'd2,
      BUS_INVAL = 2'd3
   } bus_op_type;

   typedef enum logic [1:0] {
      SNP_NONE  = 2'd0,
      SNP_NOHIT = 2'd1,
      SNP_HIT   = 2'd2,
      SNP_HITM  = 2'd3
   } snoop_reply_type;

   typedef enum logic [1:0] {
      SNP_IN_NOHIT = 2'd0,
      SNP_IN_HIT   = 2'd1,
      SNP_IN_HITM  = 2'd2
   } snoop_in_type;

   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_LOOKUP = 2'd2
   } state_type;

   typedef struct packed {
      logic            hit;
      bus_op_type      bus_op;
      logic            wb_valid;
      snoop_reply_type snoop_reply;
      logic            cnt_read;
      logic            cnt_write;
      logic            cnt_hit;
      logic            cnt_miss;
   } lookup_flags_type;

endpackage

// ===== src/mesi_last_level_cache_controller.sv =====
// Top level of the MESI last-level cache directory controller.
//
// One request transaction is taken when start is high and busy is low; it
// carries req_type, req_address and req_snoop_in. The set row is read from
// a one-port-read, one-port-write directory memory in the accept cycle,
// updated in the following cycle and written back at its end. Unless the
// request is a clear, busy is high only in that lookup cycle. The result
// appears on the rsp_ ports for exactly one cycle with rsp_valid high, in
// the cycle after the lookup, and a new request may be accepted in that
// same cycle. The receiver cannot stall: results must be taken as shown.
// The four rsp_ counters are the saturating totals after the request.
// After reset, and after a clear request, the directory is swept one set a
// cycle to the empty state, all 2**SET_INDEX_BITS sets (32768 by default),
// with busy held high; the clear request's result is given at its start.
module mesi_last_level_cache_controller #(
   parameter int SET_INDEX_BITS   = 15,
   parameter int WAYS             = 8,
   parameter int LINE_OFFSET_BITS = 6,
   parameter int ADDRESS_BITS     = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_type,
   input  logic [ADDRESS_BITS-1:0]   req_address,
   input  logic [1:0]                req_snoop_in,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic [1:0]                rsp_bus_op,
   output logic [ADDRESS_BITS-1:0]   rsp_bus_addr,
   output logic                      rsp_writeback_valid,
   output logic [ADDRESS_BITS-1:0]   rsp_writeback_addr,
   output logic [1:0]                rsp_snoop_reply,
   output logic [31:0]               rsp_read_count,
   output logic [31:0]               rsp_write_count,
   output logic [31:0]               rsp_hit_count,
   output logic [31:0]               rsp_miss_count
);
   import mlc_pkg::*;

   localparam int TAG_W = ADDRESS_BITS - SET_INDEX_BITS - LINE_OFFSET_BITS;
   localparam int AGE_W = $clog2(WAYS);
   localparam int WAY_W = TAG_W + 2 + AGE_W;
   localparam int ROW_W = WAYS * WAY_W;
   localparam int SETS  = 1 << SET_INDEX_BITS;
   localparam logic [WAY_W-1:0] EMPTY_WAY = {TAG_W'(0), CO_I, AGE_W'(WAYS - 1)};

   state_type                 state_ff, state_in;
   logic [ROW_W-1:0]          dir_mem [SETS];
   logic [ROW_W-1:0]          rdata_ff;
   logic [ROW_W-1:0]          row_new;
   logic [ROW_W-1:0]          empty_row;
   logic                      mem_we;
   logic [SET_INDEX_BITS-1:0] mem_waddr;
   logic [ROW_W-1:0]          mem_wdata;
   logic [SET_INDEX_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                      accept;
   req_code_type              req_code_ff;
   logic [ADDRESS_BITS-1:0]   addr_ff;
   logic [1:0]                snoop_ff;
   lookup_flags_type          flags;
   logic [ADDRESS_BITS-1:0]   bus_addr;
   logic [ADDRESS_BITS-1:0]   wb_addr;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      clr_cnt;
   logic [31:0]               reads_ff, writes_ff, hits_ff, misses_ff;
   logic                      rsp_hit_ff;
   logic [1:0]                rsp_bus_op_ff;
   logic [ADDRESS_BITS-1:0]   rsp_bus_addr_ff;
   logic                      rsp_wb_valid_ff;
   logic [ADDRESS_BITS-1:0]   rsp_wb_addr_ff;
   logic [1:0]                rsp_snoop_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      for (int w = 0; w < WAYS; w++) empty_row[w*WAY_W +: WAY_W] = EMPTY_WAY;
   end

   mlc_lookup #(
      .SET_INDEX_BITS   (SET_INDEX_BITS),
      .WAYS             (WAYS),
      .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
      .ADDRESS_BITS     (ADDRESS_BITS)
   ) u_lookup (
      .row_in   (rdata_ff),
      .req_code (req_code_ff),
      .address  (addr_ff),
      .snoop_in (snoop_ff),
      .row_out  (row_new),
      .flags    (flags),
      .bus_addr (bus_addr),
      .wb_addr  (wb_addr)
   );

   always_ff @(posedge clock) begin
      if (mem_we) dir_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= dir_mem[req_address[LINE_OFFSET_BITS +: SET_INDEX_BITS]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff[LINE_OFFSET_BITS +: SET_INDEX_BITS];
      mem_wdata    = row_new;
      clr_cnt      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = empty_row;
            clr_idx_in = clr_idx_ff + SET_INDEX_BITS'(1);
            if (clr_idx_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            rsp_valid_in = 1'b1;
            if (req_code_ff == REQ_CLEAR) begin
               clr_cnt    = 1'b1;
               clr_idx_in = '0;
               state_in   = ST_CLEAR;
            end else begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_code_ff <= req_code_type'(req_type);
         addr_ff     <= req_address;
         snoop_ff    <= req_snoop_in;
      end
      if (state_ff == ST_LOOKUP) begin
         rsp_hit_ff      <= flags.hit;
         rsp_bus_op_ff   <= flags.bus_op;
         rsp_bus_addr_ff <= bus_addr;
         rsp_wb_valid_ff <= flags.wb_valid;
         rsp_wb_addr_ff  <= wb_addr;
         rsp_snoop_ff    <= flags.snoop_reply;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clr_cnt) begin
         reads_ff  <= '0;
         writes_ff <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (state_ff == ST_LOOKUP) begin
         if (flags.cnt_read && reads_ff != '1) reads_ff <= reads_ff + 32'd1;
         if (flags.cnt_write && writes_ff != '1) writes_ff <= writes_ff + 32'd1;
         if (flags.cnt_hit && hits_ff != '1) hits_ff <= hits_ff + 32'd1;
         if (flags.cnt_miss && misses_ff != '1) misses_ff <= misses_ff + 32'd1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_bus_op          = rsp_bus_op_ff;
   assign rsp_bus_addr        = rsp_bus_addr_ff;
   assign rsp_writeback_valid = rsp_wb_valid_ff;
   assign rsp_writeback_addr  = rsp_wb_addr_ff;
   assign rsp_snoop_reply     = rsp_snoop_ff;
   assign rsp_read_count      = reads_ff;
   assign rsp_write_count     = writes_ff;
   assign rsp_hit_count       = hits_ff;
   assign rsp_miss_count      = misses_ff;

`ifndef SYNTHESIS
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_LOOKUP))
      else $error("result strobe without a lookup cycle");
   a_lookup_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted transaction did not enter lookup");
   a_hit_no_snoop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_snoop_reply == SNP_NONE)
      else $error("processor hit carries a snoop reply");
   a_no_write_while_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("directory written while idle");
`endif

endmodule

// ===== src/mlc_lookup.sv =====
// Set update logic: tag compare, MESI transitions, LRU aging and victim choice.
module mlc_lookup #(
   parameter int SET_INDEX_BITS   = 15,
   parameter int WAYS             = 8,
   parameter int LINE_OFFSET_BITS = 6,
   parameter int ADDRESS_BITS     = 32,
   localparam int TAG_W = ADDRESS_BITS - SET_INDEX_BITS - LINE_OFFSET_BITS,
   localparam int AGE_W = $clog2(WAYS),
   localparam int WAY_W = TAG_W + 2 + AGE_W,
   localparam int ROW_W = WAYS * WAY_W
) (
   input  logic [ROW_W-1:0]          row_in,
   input  mlc_pkg::req_code_type     req_code,
   input  logic [ADDRESS_BITS-1:0]   address,
   input  logic [1:0]                snoop_in,
   output logic [ROW_W-1:0]          row_out,
   output mlc_pkg::lookup_flags_type flags,
   output logic [ADDRESS_BITS-1:0]   bus_addr,
   output logic [ADDRESS_BITS-1:0]   wb_addr
);
   import mlc_pkg::*;

   localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);

   logic [TAG_W-1:0]          req_tag;
   logic [SET_INDEX_BITS-1:0] req_set;
   logic [TAG_W-1:0]          tg  [WAYS];
   co_type                    co  [WAYS];
   logic [AGE_W-1:0]          ag  [WAYS];
   logic [TAG_W-1:0]          ntg [WAYS];
   co_type                    nco [WAYS];
   logic [AGE_W-1:0]          nag [WAYS];
   logic                      found;
   logic [AGE_W-1:0]          hit_way;
   logic                      free_found;
   logic [AGE_W-1:0]          free_way;
   logic [AGE_W-1:0]          victim;
   logic [AGE_W-1:0]          pick;
   logic                      do_touch;
   logic [AGE_W-1:0]          touch_way;
   logic [AGE_W-1:0]          old_age;
   co_type                    fill_co;

   assign req_tag = address[ADDRESS_BITS-1 -: TAG_W];
   assign req_set = address[LINE_OFFSET_BITS +: SET_INDEX_BITS];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         tg[w] = row_in[w*WAY_W + 2 + AGE_W +: TAG_W];
         co[w] = co_type'(row_in[w*WAY_W + AGE_W +: 2]);
         ag[w] = row_in[w*WAY_W +: AGE_W];
      end

      // Downward scans leave the lowest-numbered way.
      found      = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (co[w] != CO_I && tg[w] == req_tag) begin
            found   = 1'b1;
            hit_way = AGE_W'(w);
         end
         if (co[w] == CO_I) begin
            free_found = 1'b1;
            free_way   = AGE_W'(w);
         end
      end
      victim = '0;
      for (int w = 1; w < WAYS; w++) begin
         if (ag[w] > ag[victim]) victim = AGE_W'(w);
      end
      pick    = free_found ? free_way : victim;
      fill_co = (snoop_in == SNP_IN_NOHIT) ? CO_E : CO_S;

      for (int w = 0; w < WAYS; w++) begin
         ntg[w] = tg[w];
         nco[w] = co[w];
         nag[w] = ag[w];
      end
      flags     = '0;
      bus_addr  = '0;
      wb_addr   = '0;
      do_touch  = 1'b0;
      touch_way = hit_way;

      unique case (req_code) inside
         REQ_DATA_READ, REQ_INSTR_READ, REQ_WRITE: begin
            if (req_code == REQ_WRITE) flags.cnt_write = 1'b1;
            else flags.cnt_read = 1'b1;
            do_touch = 1'b1;
            if (found) begin
               flags.hit     = 1'b1;
               flags.cnt_hit = 1'b1;
               if (req_code == REQ_WRITE) begin
                  if (co[hit_way] == CO_S) begin
                     flags.bus_op = BUS_INVAL;
                     bus_addr     = address;
                  end
                  nco[hit_way] = CO_M;
               end
            end else begin
               flags.cnt_miss = 1'b1;
               flags.bus_op   = (req_code == REQ_WRITE) ? BUS_RWIM : BUS_READ;
               bus_addr       = address;
               touch_way      = pick;
               if (!free_found && co[pick] == CO_M) begin
                  flags.wb_valid = 1'b1;
                  wb_addr = {tg[pick], req_set, LINE_OFFSET_BITS'(0)};
               end
               ntg[pick] = req_tag;
               nco[pick] = (req_code == REQ_WRITE) ? CO_M : fill_co;
            end
         end
         REQ_SNOOP_INVAL: begin
            if (found) begin
               nco[hit_way] = CO_I;
               nag[hit_way] = OLDEST;
            end
         end
         REQ_SNOOP_READ, REQ_SNOOP_RWIM: begin
            if (!found) begin
               flags.snoop_reply = SNP_NOHIT;
            end else begin
               if (co[hit_way] == CO_M) begin
                  flags.snoop_reply = SNP_HITM;
                  flags.wb_valid    = 1'b1;
                  wb_addr = {req_tag, req_set, LINE_OFFSET_BITS'(0)};
               end else begin
                  flags.snoop_reply = SNP_HIT;
               end
               if (req_code == REQ_SNOOP_READ) begin
                  nco[hit_way] = CO_S;
               end else begin
                  nco[hit_way] = CO_I;
                  nag[hit_way] = OLDEST;
               end
            end
         end
         default: ;
      endcase

      if (do_touch) begin
         old_age = ag[touch_way];
         for (int w = 0; w < WAYS; w++) begin
            if (ag[w] < old_age) nag[w] = ag[w] + AGE_W'(1);
         end
         nag[touch_way] = '0;
      end else begin
         old_age = '0;
      end

      for (int w = 0; w < WAYS; w++) begin
         row_out[w*WAY_W +: WAY_W] = {ntg[w], nco[w], nag[w]};
      end
   end

endmodule

// ===== tb/sv/mesi_last_level_cache_controller_tb.sv =====
// Self-checking testbench of the MESI last-level cache directory controller.
`timescale 1ns / 100ps

module mesi_last_level_cache_controller_tb;
   import mlc_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   typedef struct packed {
      logic            hit;
      bus_op_type      bus_op;
      logic [31:0]     bus_addr;
      logic            wb_valid;
      logic [31:0]     wb_addr;
      snoop_reply_type reply;
      logic [31:0]     reads;
      logic [31:0]     writes;
      logic [31:0]     hits;
      logic [31:0]     misses;
   } cache_outcome_type;

   typedef struct {
      req_code_type      code;
      logic [31:0]       addr;
      logic [1:0]        snp;
      bit                typed;
      cache_outcome_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_type = '0;
   logic [31:0] req_address = '0;
   logic [1:0]  req_snoop_in = '0;
   logic        busy, rsp_valid, rsp_hit, rsp_writeback_valid;
   logic [1:0]  rsp_bus_op, rsp_snoop_reply;
   logic [31:0] rsp_bus_addr, rsp_writeback_addr;
   logic [31:0] rsp_read_count, rsp_write_count, rsp_hit_count, rsp_miss_count;

   // Directory copy: index is set * 8 + way; missing entries hold reset values.
   logic [10:0] dir_tag [int];
   co_type      dir_co  [int];
   logic [2:0]  dir_age [int];
   logic [31:0] reads_seen, writes_seen, hits_seen, misses_seen;

   cache_outcome_type pending_q[$];
   stim_row_type      rows[$];
   int                errors = 0;
   int                idle_cycles = 0;
   int                send_idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mesi_last_level_cache_controller u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_address(req_address), .req_snoop_in(req_snoop_in),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_bus_op(rsp_bus_op),
      .rsp_bus_addr(rsp_bus_addr), .rsp_writeback_valid(rsp_writeback_valid),
      .rsp_writeback_addr(rsp_writeback_addr), .rsp_snoop_reply(rsp_snoop_reply),
      .rsp_read_count(rsp_read_count), .rsp_write_count(rsp_write_count),
      .rsp_hit_count(rsp_hit_count), .rsp_miss_count(rsp_miss_count)
   );

   function automatic co_type co_at(int idx);
      return dir_co.exists(idx) ? dir_co[idx] : CO_I;
   endfunction

   function automatic logic [2:0] age_at(int idx);
      return dir_age.exists(idx) ? dir_age[idx] : 3'd7;
   endfunction

   function automatic logic [10:0] tag_at(int idx);
      return dir_tag.exists(idx) ? dir_tag[idx] : 11'd0;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic void clear_directory();
      dir_tag.delete();
      dir_co.delete();
      dir_age.delete();
      reads_seen = '0;
      writes_seen = '0;
      hits_seen = '0;
      misses_seen = '0;
   endfunction

   function automatic void make_youngest(int base, int way);
      logic [2:0] old;
      old = age_at(base + way);
      for (int i = 0; i < 8; i++)
         if (age_at(base + i) < old) dir_age[base + i] = age_at(base + i) + 3'd1;
      dir_age[base + way] = 3'd0;
   endfunction

   // Gives a missing line a free way, else the oldest; an M victim is written back.
   function automatic void allocate_line(int base, logic [14:0] set, logic [10:0] tag,
                                         co_type co, inout cache_outcome_type r);
      int pick;
      pick = -1;
      for (int w = 0; w < 8; w++)
         if (pick < 0 && co_at(base + w) == CO_I) pick = w;
      if (pick < 0) begin
         pick = 0;
         for (int w = 1; w < 8; w++)
            if (age_at(base + w) > age_at(base + pick)) pick = w;
         if (co_at(base + pick) == CO_M) begin
            r.wb_valid = 1'b1;
            r.wb_addr = {tag_at(base + pick), set, 6'd0};
         end
      end
      dir_tag[base + pick] = tag;
      dir_co[base + pick] = co;
      make_youngest(base, pick);
   endfunction

   function automatic cache_outcome_type predict_directory(req_code_type code,
                                                           logic [31:0] addr,
                                                           logic [1:0] snp);
      cache_outcome_type r;
      logic [14:0]       set;
      logic [10:0]       tag;
      int                base, w;
      r = '0;
      set = addr[20:6];
      tag = addr[31:21];
      base = int'(set) * 8;
      w = -1;
      for (int i = 7; i >= 0; i--)
         if (co_at(base + i) != CO_I && tag_at(base + i) == tag) w = i;
      case (code) inside
         REQ_DATA_READ, REQ_INSTR_READ: begin
            reads_seen = bump(reads_seen);
            if (w >= 0) begin
               hits_seen = bump(hits_seen);
               r.hit = 1'b1;
               make_youngest(base, w);
            end else begin
               misses_seen = bump(misses_seen);
               r.bus_op = BUS_READ;
               r.bus_addr = addr;
               allocate_line(base, set, tag, (snp == SNP_IN_NOHIT) ? CO_E : CO_S, r);
            end
         end
         REQ_WRITE: begin
            writes_seen = bump(writes_seen);
            if (w >= 0) begin
               hits_seen = bump(hits_seen);
               r.hit = 1'b1;
               if (co_at(base + w) == CO_S) begin
                  r.bus_op = BUS_INVAL;
                  r.bus_addr = addr;
               end
               dir_co[base + w] = CO_M;
               make_youngest(base, w);
            end else begin
               misses_seen = bump(misses_seen);
               r.bus_op = BUS_RWIM;
               r.bus_addr = addr;
               allocate_line(base, set, tag, CO_M, r);
            end
         end
         REQ_SNOOP_INVAL: begin
            if (w >= 0) begin
               dir_co[base + w] = CO_I;
               dir_age[base + w] = 3'd7;
            end
         end
         REQ_SNOOP_READ, REQ_SNOOP_RWIM: begin
            if (w < 0) begin
               r.reply = SNP_NOHIT;
            end else begin
               if (co_at(base + w) == CO_M) begin
                  r.reply = SNP_HITM;
                  r.wb_valid = 1'b1;
                  r.wb_addr = {tag, set, 6'd0};
               end else begin
                  r.reply = SNP_HIT;
               end
               if (code == REQ_SNOOP_READ) begin
                  dir_co[base + w] = CO_S;
               end else begin
                  dir_co[base + w] = CO_I;
                  dir_age[base + w] = 3'd7;
               end
            end
         end
         REQ_CLEAR: clear_directory();
         default: ;
      endcase
      r.reads = reads_seen;
      r.writes = writes_seen;
      r.hits = hits_seen;
      r.misses = misses_seen;
      return r;
   endfunction

   function automatic cache_outcome_type outcome(logic hit, bus_op_type op,
                                                 logic [31:0] ba, logic wb,
                                                 logic [31:0] wa, snoop_reply_type sr,
                                                 logic [31:0] rd, logic [31:0] wr,
                                                 logic [31:0] ht, logic [31:0] ms);
      cache_outcome_type r;
      r = '{hit, op, ba, wb, wa, sr, rd, wr, ht, ms};
      return r;
   endfunction

   function automatic void add_row(req_code_type code, logic [31:0] addr, logic [1:0] snp,
                                   bit typed = 1'b0, cache_outcome_type want = '0);
      stim_row_type row;
      row.code = code;
      row.addr = addr;
      row.snp = snp;
      row.typed = typed;
      row.want = want;
      rows.push_back(row);
   endfunction

   // Presents one transaction, holds it until accepted, and records its outcome.
   task automatic send_request(req_code_type code, logic [31:0] addr, logic [1:0] snp,
                               bit typed = 1'b0, cache_outcome_type want = '0);
      cache_outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= code;
      req_address <= addr;
      req_snoop_in <= snp;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predicted = predict_directory(code, addr, snp);
      pending_q.push_back(typed ? want : predicted);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pool_address();
      logic [14:0] set;
      logic [10:0] tag;
      case ($urandom_range(3))
         0: set = 15'd0;
         1: set = 15'h7FFF;
         2: set = 15'd1;
         default: set = 15'h2A55;
      endcase
      tag = ($urandom_range(11) == 11) ? 11'h7FF : 11'($urandom_range(10));
      return {tag, set, 6'($urandom_range(63))};
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (rsp_valid) begin
            cache_outcome_type got, exp_o;
            got = '{rsp_hit, bus_op_type'(rsp_bus_op), rsp_bus_addr, rsp_writeback_valid,
                    rsp_writeback_addr, snoop_reply_type'(rsp_snoop_reply),
                    rsp_read_count, rsp_write_count, rsp_hit_count, rsp_miss_count};
            if (pending_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transaction result %p", got);
            end else begin
               exp_o = pending_q.pop_front();
               if (got !== exp_o) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %p, got %p", exp_o, got);
               end
            end
         end
      end
   end

   initial begin
      int kind;
      req_code_type code;
      logic [31:0] addr;
      clear_directory();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: hit/miss transitions, extremes, set overflow, and clear.
      add_row(REQ_DATA_READ, 32'h0, SNP_IN_NOHIT, 1'b1,
              outcome(1'b0, BUS_READ, 32'h0, 1'b0, 32'h0, SNP_NONE, 1, 0, 0, 1));
      add_row(REQ_DATA_READ, 32'h0, SNP_IN_NOHIT, 1'b1,
              outcome(1'b1, BUS_NONE, 32'h0, 1'b0, 32'h0, SNP_NONE, 2, 0, 1, 1));
      add_row(REQ_WRITE, 32'h0, SNP_IN_NOHIT, 1'b1,
              outcome(1'b1, BUS_NONE, 32'h0, 1'b0, 32'h0, SNP_NONE, 2, 1, 2, 1));
      add_row(REQ_SNOOP_READ, 32'h3F, SNP_IN_NOHIT, 1'b1,
              outcome(1'b0, BUS_NONE, 32'h0, 1'b1, 32'h0, SNP_HITM, 2, 1, 2, 1));
      add_row(REQ_WRITE, 32'h0, SNP_IN_HIT);
      add_row(REQ_SNOOP_RWIM, 32'h0, SNP_IN_NOHIT);
      add_row(REQ_SNOOP_RWIM, 32'h0, SNP_IN_NOHIT);
      add_row(REQ_INSTR_READ, 32'hFFFF_FFFF, SNP_IN_HITM);
      add_row(REQ_SNOOP_WRITE, 32'hFFFF_FFFF, SNP_IN_NOHIT);
      add_row(REQ_SNOOP_READ, 32'hFFFF_FFFF, SNP_IN_NOHIT);
      add_row(REQ_SNOOP_INVAL, 32'hFFFF_FFFF, SNP_IN_NOHIT);
      add_row(REQ_DATA_READ, 32'hFFFF_FFFF, 2'd3);
      for (int t = 1; t <= 9; t++)
         add_row(REQ_WRITE, {11'(t), 15'h7FFF, 6'd0}, SNP_IN_HIT);
      add_row(REQ_SNOOP_READ, {11'd9, 15'h7FFF, 6'd0}, SNP_IN_NOHIT);
      add_row(REQ_CLEAR, 32'h0, SNP_IN_NOHIT, 1'b1, '0);
      foreach (rows[i]) send_request(rows[i].code, rows[i].addr, rows[i].snp,
                                     rows[i].typed, rows[i].want);

      for (int n = 0; n < 1950; n++) begin
         case (n / 488)
            0: send_idle_pct = 0;
            1: send_idle_pct = 50;
            2: send_idle_pct = 21;
            default: send_idle_pct = 0;
         endcase
         if (n == 1000) drain();
         kind = $urandom_range(999);
         if (kind < 3) begin
            code = REQ_CLEAR;
         end else if (kind < 600) begin
            case ($urandom_range(2))
               0: code = REQ_DATA_READ;
               1: code = REQ_WRITE;
               default: code = REQ_INSTR_READ;
            endcase
         end else begin
            code = req_code_type'($urandom_range(3, 6));
         end
         addr = ($urandom_range(4) == 0) ? $urandom : pool_address();
         send_request(code, addr, 2'($urandom_range(3)));
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
